>>> sv/tted_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tted_pkg
// Shared widths, register indexes, mixing constants and pipeline types for
// the three-tap echo delay.
// ----------------------------------------------------------------------------
package tted_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int OUT_W      = 18;
    localparam int DELAY_W    = 16;
    localparam int GAIN_W     = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_GAIN    = 2'd1;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = 17'd65536;

    // weighted tap sum 6*s1 + 3*s2 + 2*s3
    localparam int WSUM_W    = 20;
    localparam int PROD_W    = 37;
    localparam int GAIN_FRAC = 16;
    localparam int SHIFT_W   = PROD_W - GAIN_FRAC;

    // floor(v / 6) via bias to non-negative, reciprocal multiply, unbias
    localparam int UNS_W       = 20;
    localparam int RECIP_W     = 21;
    localparam int RPROD_W     = 41;
    localparam int RECIP_SHIFT = 23;
    localparam int QUO_W       = 17;
    localparam logic [RECIP_W-1:0]        RECIP_SIX  = 21'd1398102;
    localparam logic signed [SHIFT_W-1:0] FLOOR_BIAS = 21'sd360450;
    localparam logic signed [OUT_W-1:0]   QUO_BIAS   = 18'sd60075;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [OUT_W-1:0]    t_mixed;

    typedef struct packed {
        logic en2;
        logic en3;
        logic en4;
    } t_pipe_en;

endpackage

>>> sv/three_tap_echo_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_tap_echo_delay
// Feedforward echo: dry sample plus three taps at D+1, 2D+1, 3D+1 samples,
// weighted by g, g/2 and g/3.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_sample_valid / o_sample_ready carries i_sample_in; output
//   channel o_mixed_valid / i_mixed_ready carries o_mixed_out. A transaction
//   takes place when valid and ready are both high at a rising edge.
//   Pipeline: o_mixed_valid flags the last stage. Throughput: one sample per
//   cycle unless stalled, clearing or updating tap offsets; the history lives
//   in two mirrored memories (one with two read ports, one with one) so all
//   three taps are read in the cycle the sample is written.
//   Reset: the history is swept to zero with o_sample_ready low;
//   configuration writes are taken during the sweep.
//   Config: i_cfg_we writes i_cfg_data to register i_cfg_index at once
//   (0 delay_length, 1 echo_gain). A delay_length write reduces the tap
//   offsets modulo the depth by reciprocal multiplication, keeping
//   o_sample_ready low while it runs.
//   Stall: the pipeline holds when i_mixed_ready is low; empty stages still
//   fill, so input transactions continue until every stage holds a result.
// ----------------------------------------------------------------------------
module three_tap_echo_delay #(
    parameter int HISTORY_DEPTH  = 262144,
    parameter int MAX_BASE_DELAY = 65535
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_sample_valid,
    output logic                            o_sample_ready,
    input  tted_pkg::t_sample               i_sample_in,
    output logic                            o_mixed_valid,
    input  logic                            i_mixed_ready,
    output tted_pkg::t_mixed                o_mixed_out,
    input  logic                            i_cfg_we,
    input  logic [tted_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tted_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(HISTORY_DEPTH);

    logic [tted_pkg::GAIN_W-1:0] r_gain;
    logic [AW-1:0]               r_wp;
    logic                        r_v1;
    logic                        r_v2;
    logic                        r_v3;
    logic                        r_v4;
    tted_pkg::t_sample           r_x1;
    logic [2:0]                  r_fw1;

    logic                        w_tap_start;
    logic                        w_tap_busy;
    logic                        w_clearing;
    logic                        w_busy;
    logic                        w_en1;
    tted_pkg::t_pipe_en          w_en;
    logic                        w_accept;
    logic [AW-1:0]               w_off [3];
    logic [AW-1:0]               w_raddr [3];
    logic [AW:0]                 w_wrap [3];
    tted_pkg::t_sample           w_q1;
    tted_pkg::t_sample           w_q2;
    tted_pkg::t_sample           w_q3;
    tted_pkg::t_sample           w_tap1;
    tted_pkg::t_sample           w_tap2;
    tted_pkg::t_sample           w_tap3;

    // configuration
    assign w_tap_start = i_cfg_we && (i_cfg_index == tted_pkg::REG_DELAY_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tted_pkg::REG_ECHO_GAIN: begin
                    r_gain <= (i_cfg_data > tted_pkg::GAIN_UNITY) ?
                              tted_pkg::GAIN_UNITY : i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    tted_tapmod #(
        .HISTORY_DEPTH  (HISTORY_DEPTH),
        .MAX_BASE_DELAY (MAX_BASE_DELAY)
    ) u_tapmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_tap_start),
        .i_delay (i_cfg_data[tted_pkg::DELAY_W-1:0]),
        .o_busy  (w_tap_busy),
        .o_off1  (w_off[0]),
        .o_off2  (w_off[1]),
        .o_off3  (w_off[2])
    );

    // pipeline control: a stage loads when it is empty or the next one moves
    assign w_en.en4 = !r_v4 || i_mixed_ready;
    assign w_en.en3 = !r_v3 || w_en.en4;
    assign w_en.en2 = !r_v2 || w_en.en3;
    assign w_en1    = !r_v1 || w_en.en2;
    assign w_busy   = w_clearing || w_tap_busy;

    assign o_sample_ready = w_en1 && !w_busy;
    assign w_accept       = i_sample_valid && o_sample_ready;

    // tap addresses behind the write pointer, wrapped into the store
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_wrap[k]  = (AW + 1)'(r_wp) + (AW + 1)'(HISTORY_DEPTH) - (AW + 1)'(w_off[k]);
            w_raddr[k] = (r_wp >= w_off[k]) ? (r_wp - w_off[k]) : w_wrap[k][AW-1:0];
        end
    end

    tted_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_history (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_accept),
        .i_wr_addr  (r_wp),
        .i_wr_data  (i_sample_in),
        .i_rd_en    (w_accept),
        .i_rd_addr1 (w_raddr[0]),
        .i_rd_addr2 (w_raddr[1]),
        .i_rd_addr3 (w_raddr[2]),
        .o_rd_data1 (w_q1),
        .o_rd_data2 (w_q2),
        .o_rd_data3 (w_q3),
        .o_clearing (w_clearing)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_accept) begin
                r_wp <= (r_wp == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (w_en1) begin
                r_v1 <= w_accept;
            end
            if (w_en.en2) begin
                r_v2 <= r_v1;
            end
            if (w_en.en3) begin
                r_v3 <= r_v2;
            end
            if (w_en.en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // tap offset zero means the tap is the sample written this transaction
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x1  <= i_sample_in;
            r_fw1 <= {w_off[2] == '0, w_off[1] == '0, w_off[0] == '0};
        end
    end

    assign w_tap1 = r_fw1[0] ? r_x1 : w_q1;
    assign w_tap2 = r_fw1[1] ? r_x1 : w_q2;
    assign w_tap3 = r_fw1[2] ? r_x1 : w_q3;

    tted_mix u_mix (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_tap1  (w_tap1),
        .i_tap2  (w_tap2),
        .i_tap3  (w_tap3),
        .i_dry   (r_x1),
        .i_gain  (r_gain),
        .o_mixed (o_mixed_out)
    );

    assign o_mixed_valid = r_v4;

`ifndef SYNTHESIS
    a_no_accept_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !o_sample_ready)
        else $error("sample accepted while clearing or reducing tap offsets");

    a_wp_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (r_wp != AW'(HISTORY_DEPTH - 1)) |=> r_wp == $past(r_wp) + AW'(1))
        else $error("write pointer did not advance on transaction");

    a_out_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v4) |-> $past(r_v3))
        else $error("result appeared without a stage 3 entry");

    a_stage1_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v1) |-> $past(w_accept))
        else $error("stage 1 filled without an input transaction");
`endif

endmodule

>>> sv/tted_tapmod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tted_tapmod
// Tap offset unit: clamps the base delay and reduces the three tap delays
// D+1, 2D+1, 3D+1 modulo the history depth by reciprocal multiplication,
// a quotient step followed by a remainder step per update.
// ----------------------------------------------------------------------------
module tted_tapmod #(
    parameter int HISTORY_DEPTH  = 262144,
    parameter int MAX_BASE_DELAY = 65535
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [tted_pkg::DELAY_W-1:0]     i_delay,
    output logic                             o_busy,
    output logic [$clog2(HISTORY_DEPTH)-1:0] o_off1,
    output logic [$clog2(HISTORY_DEPTH)-1:0] o_off2,
    output logic [$clog2(HISTORY_DEPTH)-1:0] o_off3
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int TW = $clog2(3 * MAX_BASE_DELAY + 2);
    localparam int MW = TW + 2;
    localparam int RW = TW + AW;
    localparam int PW = RW + TW;
    // ceil(2^RW / depth); exact quotient for any tap below 2^TW
    localparam longint unsigned RECIP =
        ((64'd1 << RW) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);

    logic                         r_busy;
    logic                         r_phase;
    logic [TW-1:0]                r_t [3];
    logic [TW-1:0]                r_q [3];
    logic [AW-1:0]                r_off [3];
    logic [PW-1:0]                w_prod [3];
    logic [TW-1:0]                w_q [3];
    logic [RW-1:0]                w_rem [3];
    logic [tted_pkg::DELAY_W-1:0] w_dclamp;
    logic [TW-1:0]                w_d;

    assign w_dclamp = (32'(i_delay) > 32'(MAX_BASE_DELAY)) ?
                      tted_pkg::DELAY_W'(MAX_BASE_DELAY) : i_delay;
    assign w_d      = TW'(w_dclamp);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_prod[k] = PW'(r_t[k]) * PW'(MW'(RECIP));
            w_q[k]    = w_prod[k][RW +: TW];
            w_rem[k]  = RW'(r_t[k]) - RW'(r_q[k]) * RW'(HISTORY_DEPTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_t[0] <= w_d + TW'(1);
            r_t[1] <= (w_d << 1) + TW'(1);
            r_t[2] <= (w_d << 1) + w_d + TW'(1);
        end
        if (r_busy && !r_phase) begin
            for (int k = 0; k < 3; k++) begin
                r_q[k] <= w_q[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_off[k] <= AW'(1);
            end
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_phase <= 1'b0;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_phase <= 1'b1;
            end else begin
                for (int k = 0; k < 3; k++) begin
                    r_off[k] <= w_rem[k][AW-1:0];
                end
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_off1 = r_off[0];
    assign o_off2 = r_off[1];
    assign o_off3 = r_off[2];

endmodule

>>> sv/tted_history.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tted_history
// Sample history: two mirrored single-write memories giving three registered
// read ports, plus the post-reset clearing sweep.
// ----------------------------------------------------------------------------
module tted_history #(
    parameter int HISTORY_DEPTH = 262144
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] i_wr_addr,
    input  tted_pkg::t_sample                i_wr_data,
    input  logic                             i_rd_en,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] i_rd_addr1,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] i_rd_addr2,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] i_rd_addr3,
    output tted_pkg::t_sample                o_rd_data1,
    output tted_pkg::t_sample                o_rd_data2,
    output tted_pkg::t_sample                o_rd_data3,
    output logic                             o_clearing
);

    localparam int AW = $clog2(HISTORY_DEPTH);

    tted_pkg::t_sample r_mem_a [HISTORY_DEPTH];
    tted_pkg::t_sample r_mem_b [HISTORY_DEPTH];
    tted_pkg::t_sample r_q1;
    tted_pkg::t_sample r_q2;
    tted_pkg::t_sample r_q3;

    logic              r_clearing;
    logic [AW-1:0]     r_clr_addr;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    tted_pkg::t_sample w_wdata;

    assign w_we    = r_clearing | i_wr_en;
    assign w_waddr = r_clearing ? r_clr_addr : i_wr_addr;
    assign w_wdata = r_clearing ? '0 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(HISTORY_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_a[w_waddr] <= w_wdata;
        end
        if (i_rd_en) begin
            r_q1 <= r_mem_a[i_rd_addr1];
            r_q2 <= r_mem_a[i_rd_addr2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_b[w_waddr] <= w_wdata;
        end
        if (i_rd_en) begin
            r_q3 <= r_mem_b[i_rd_addr3];
        end
    end

    assign o_rd_data1 = r_q1;
    assign o_rd_data2 = r_q2;
    assign o_rd_data3 = r_q3;
    assign o_clearing = r_clearing;

endmodule

>>> sv/tted_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tted_mix
// Echo mixer: weights the three taps by the gain, floors the sum divided by
// 6 * 65536 and adds the dry sample. Three registered stages.
// ----------------------------------------------------------------------------
module tted_mix (
    input  logic                        i_clk,
    input  tted_pkg::t_pipe_en          i_en,
    input  tted_pkg::t_sample           i_tap1,
    input  tted_pkg::t_sample           i_tap2,
    input  tted_pkg::t_sample           i_tap3,
    input  tted_pkg::t_sample           i_dry,
    input  logic [tted_pkg::GAIN_W-1:0] i_gain,
    output tted_pkg::t_mixed            o_mixed
);

    logic signed [tted_pkg::WSUM_W-1:0]  w_t1;
    logic signed [tted_pkg::WSUM_W-1:0]  w_t2;
    logic signed [tted_pkg::WSUM_W-1:0]  w_t3;
    logic signed [tted_pkg::WSUM_W-1:0]  w_wsum;
    logic signed [tted_pkg::PROD_W-1:0]  w_prod;
    logic signed [tted_pkg::SHIFT_W-1:0] w_shift;
    logic signed [tted_pkg::SHIFT_W-1:0] w_biased;
    logic [tted_pkg::RPROD_W-1:0]        w_rprod;
    logic [tted_pkg::QUO_W-1:0]          w_quo;
    tted_pkg::t_mixed                    w_dry_ext;
    tted_pkg::t_mixed                    w_quo_ext;
    tted_pkg::t_mixed                    w_y;

    logic signed [tted_pkg::PROD_W-1:0]  r_prod;
    tted_pkg::t_sample                   r_dry2;
    logic [tted_pkg::RPROD_W-1:0]        r_rprod;
    tted_pkg::t_sample                   r_dry3;
    tted_pkg::t_mixed                    r_y;

    // stage 2: 6*s1 + 3*s2 + 2*s3, times gain
    assign w_t1   = tted_pkg::WSUM_W'(i_tap1);
    assign w_t2   = tted_pkg::WSUM_W'(i_tap2);
    assign w_t3   = tted_pkg::WSUM_W'(i_tap3);
    assign w_wsum = (w_t1 <<< 2) + (w_t1 <<< 1) + (w_t2 <<< 1) + w_t2 + (w_t3 <<< 1);
    assign w_prod = tted_pkg::PROD_W'(w_wsum)
                  * tted_pkg::PROD_W'($signed({1'b0, i_gain}));

    // stage 3: floor by 65536, bias non-negative, times reciprocal of 6
    assign w_shift  = $signed(r_prod[tted_pkg::PROD_W-1:tted_pkg::GAIN_FRAC]);
    assign w_biased = w_shift + tted_pkg::FLOOR_BIAS;
    assign w_rprod  = tted_pkg::RPROD_W'(w_biased[tted_pkg::UNS_W-1:0])
                    * tted_pkg::RPROD_W'(tted_pkg::RECIP_SIX);

    // stage 4: unbias and add the dry sample
    assign w_quo     = r_rprod[tted_pkg::RECIP_SHIFT +: tted_pkg::QUO_W];
    assign w_dry_ext = tted_pkg::OUT_W'(r_dry3);
    assign w_quo_ext = $signed({1'b0, w_quo});
    assign w_y       = w_dry_ext + w_quo_ext - tted_pkg::QUO_BIAS;

    always_ff @(posedge i_clk) begin
        if (i_en.en2) begin
            r_prod <= w_prod;
            r_dry2 <= i_dry;
        end
        if (i_en.en3) begin
            r_rprod <= w_rprod;
            r_dry3  <= r_dry2;
        end
        if (i_en.en4) begin
            r_y <= w_y;
        end
    end

    assign o_mixed = r_y;

endmodule

>>> verif/three_tap_echo_delay_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_tap_echo_delay_tb
// Streams signed samples through the echo block under changing delay and gain
// settings and random idling on both channels. A fixed-point echo predictor
// with its own history copy computes each mixed output, and every output
// transaction is compared in order against it.
// ----------------------------------------------------------------------------
module three_tap_echo_delay_tb;

    localparam int HIST_DEPTH      = 262144;
    localparam int BASE_DELAY_MAX  = 65535;
    localparam longint ECHO_DIV    = 6 * 65536;
    localparam int STALL_LIMIT     = 800000;
    localparam int SETTLE_CYCLES   = 6;
    localparam int RANDOM_ITEMS    = 1530;
    localparam logic [tted_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [tted_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    class echo_mix_predictor;
        shortint           history_mem [HIST_DEPTH];
        int                wr_pos;
        int unsigned       base_delay;
        int unsigned       echo_gain;
        tted_pkg::t_mixed  mix_queue [$];
        int                mismatches;

        function void set_reg(logic [tted_pkg::CFG_IDX_W-1:0] idx,
                              logic [tted_pkg::CFG_DATA_W-1:0] data);
            if (idx == tted_pkg::REG_DELAY_LENGTH) begin
                base_delay = int'(data[tted_pkg::DELAY_W-1:0]);
            end else if (idx == tted_pkg::REG_ECHO_GAIN) begin
                echo_gain = int'(data[tted_pkg::GAIN_W-1:0]);
            end
        endfunction

        function longint tap_read(longint dly);
            int idx;
            idx = int'((longint'(wr_pos) + HIST_DEPTH - (dly % HIST_DEPTH)) % HIST_DEPTH);
            return longint'(history_mem[idx]);
        endfunction

        function void take_sample(tted_pkg::t_sample x);
            longint d, g, s1, s2, s3, num, q;
            d = (base_delay > BASE_DELAY_MAX) ? BASE_DELAY_MAX : base_delay;
            g = (echo_gain > 65536) ? 65536 : echo_gain;
            history_mem[wr_pos] = x;
            s1 = tap_read(d + 1);
            s2 = tap_read(2 * d + 1);
            s3 = tap_read(3 * d + 1);
            num = 6 * g * s1 + 3 * g * s2 + 2 * g * s3;
            q = num / ECHO_DIV;
            if ((num % ECHO_DIV) != 0 && num < 0) q = q - 1;
            mix_queue.push_back(tted_pkg::t_mixed'(longint'(x) + q));
            wr_pos = (wr_pos + 1) % HIST_DEPTH;
        endfunction

        function void check_mix(tted_pkg::t_mixed got);
            tted_pkg::t_mixed want;
            if (mix_queue.size() == 0) begin
                $error("mixed_out: unexpected transaction, actual %0d", got);
                mismatches++;
            end else begin
                want = mix_queue.pop_front();
                if (got !== want) begin
                    $error("mixed_out: expected %0d, actual %0d", want, got);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_sample_valid;
    logic                            o_sample_ready;
    tted_pkg::t_sample               i_sample_in;
    logic                            o_mixed_valid;
    logic                            i_mixed_ready;
    tted_pkg::t_mixed                o_mixed_out;
    logic                            i_cfg_we;
    logic [tted_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [tted_pkg::CFG_DATA_W-1:0] i_cfg_data;

    echo_mix_predictor mix_model;
    bit                steady;
    int                stall_cycles;

    three_tap_echo_delay u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample_in    (i_sample_in),
        .o_mixed_valid  (o_mixed_valid),
        .i_mixed_ready  (i_mixed_ready),
        .o_mixed_out    (o_mixed_out),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_mixed_ready <= steady || ($urandom_range(99) >= 9);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_mixed_valid && i_mixed_ready) mix_model.check_mix(o_mixed_out);
    end

    always @(posedge i_clk) begin
        if ((i_sample_valid && o_sample_ready) || (o_mixed_valid && i_mixed_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // called just after a falling edge; returns just after a falling edge
    task automatic send_sample(input tted_pkg::t_sample s);
        while (!steady && $urandom_range(99) < 9) begin
            i_sample_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_sample_valid <= 1'b1;
        i_sample_in    <= s;
        do @(posedge i_clk); while (!o_sample_ready);
        mix_model.take_sample(s);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [tted_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tted_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        mix_model.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    // drain all outstanding transactions before touching the registers
    task automatic drain;
        i_sample_valid <= 1'b0;
        @(negedge i_clk);
        while (mix_model.mix_queue.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic tted_pkg::t_sample pick_sample();
        case ($urandom_range(9))
            0:       return tted_pkg::t_sample'(16'h8000);
            1:       return tted_pkg::t_sample'(16'h7fff);
            2:       return tted_pkg::t_sample'($urandom_range(0, 63))
                            - tted_pkg::t_sample'(32);
            default: return tted_pkg::t_sample'($urandom());
        endcase
    endfunction

    function automatic logic [tted_pkg::CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(5))
            0:       return '0;
            1:       return tted_pkg::CFG_DATA_W'(tted_pkg::GAIN_UNITY);
            2:       return '1;
            3:       return tted_pkg::CFG_DATA_W'($urandom_range(0, 65536));
            default: return tted_pkg::CFG_DATA_W'($urandom_range(0, 131071));
        endcase
    endfunction

    function automatic logic [tted_pkg::CFG_DATA_W-1:0] pick_delay();
        logic [tted_pkg::CFG_DATA_W-1:0] v;
        case ($urandom_range(9))
            0:       v = tted_pkg::CFG_DATA_W'(BASE_DELAY_MAX);
            1:       v = tted_pkg::CFG_DATA_W'($urandom_range(0, 65535));
            2:       v = '0;
            default: v = tted_pkg::CFG_DATA_W'($urandom_range(0, 24));
        endcase
        v[tted_pkg::CFG_DATA_W-1] = $urandom_range(1);
        return v;
    endfunction

    initial begin
        int sent;
        int phase;
        int n;
        mix_model      = new;
        steady         = 1'b0;
        stall_cycles   = 0;
        i_rst_n        = 1'b0;
        i_sample_valid = 1'b0;
        i_sample_in    = '0;
        i_mixed_ready  = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = tted_pkg::REG_DELAY_LENGTH;
        i_cfg_data     = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // dry path only, sample extremes
        send_sample(tted_pkg::t_sample'(16'h8000));
        send_sample(tted_pkg::t_sample'(16'h7fff));
        send_sample('0);
        send_sample(-tted_pkg::t_sample'(1));
        send_sample(tted_pkg::t_sample'(1));
        drain();

        // unity gain, all taps one sample back: largest magnitudes
        write_reg(tted_pkg::REG_ECHO_GAIN, tted_pkg::CFG_DATA_W'(tted_pkg::GAIN_UNITY));
        repeat (4) send_sample(tted_pkg::t_sample'(16'h8000));
        repeat (4) send_sample(tted_pkg::t_sample'(16'h7fff));
        drain();

        // gain above unity saturates; spare register indexes are ignored
        write_reg(tted_pkg::REG_DELAY_LENGTH, tted_pkg::CFG_DATA_W'(1));
        write_reg(tted_pkg::REG_ECHO_GAIN, '1);
        write_reg(REG_SPARE_2, '1);
        write_reg(REG_SPARE_3, tted_pkg::CFG_DATA_W'(17'h0a5a5));
        repeat (6) send_sample(pick_sample());
        drain();

        // longest base delay: taps land in never-written history
        write_reg(tted_pkg::REG_DELAY_LENGTH, tted_pkg::CFG_DATA_W'(BASE_DELAY_MAX));
        send_sample(tted_pkg::t_sample'(16'h7fff));
        send_sample(tted_pkg::t_sample'(16'h8000));
        send_sample(tted_pkg::t_sample'(16'h5555));
        drain();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(4))
                0: write_reg(tted_pkg::REG_DELAY_LENGTH, pick_delay());
                1: write_reg(tted_pkg::REG_ECHO_GAIN, pick_gain());
                2: begin
                    write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
                              tted_pkg::CFG_DATA_W'($urandom()));
                    write_reg(tted_pkg::REG_ECHO_GAIN, pick_gain());
                end
                default: begin
                    write_reg(tted_pkg::REG_DELAY_LENGTH, pick_delay());
                    write_reg(tted_pkg::REG_ECHO_GAIN, pick_gain());
                end
            endcase
            steady = (phase == 3);
            n = $urandom_range(40, 160);
            if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
            repeat (n) send_sample(pick_sample());
            sent += n;
            drain();
            steady = 1'b0;
            phase++;
        end

        if (mix_model.mismatches == 0 && mix_model.mix_queue.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/tted_pkg.sv
sv/tted_tapmod.sv
sv/tted_history.sv
sv/tted_mix.sv
sv/three_tap_echo_delay.sv
verif/three_tap_echo_delay_tb.sv
